/* rtl/core/osm_pkg.sv */
package osm_pkg;

  localparam int unsigned CodeWidth   = 16;
  localparam int unsigned PhaseWidth  = 3;
  localparam int unsigned ActionWidth = 2;
  localparam int unsigned RegIdxWidth = 2;

  typedef logic [CodeWidth-1:0]   code_t;
  typedef logic [PhaseWidth-1:0]  phase_t;
  typedef logic [ActionWidth-1:0] action_t;
  typedef logic [RegIdxWidth-1:0] reg_idx_t;

  localparam action_t ACT_NONE    = 2'd0;
  localparam action_t ACT_ENGAGE  = 2'd1;
  localparam action_t ACT_RELEASE = 2'd2;

  localparam reg_idx_t REG_TRIGGER_CODE   = 2'd0;
  localparam reg_idx_t REG_TARGET_CODE    = 2'd1;
  localparam reg_idx_t REG_ACTIVE_TIMEOUT = 2'd2;
  localparam reg_idx_t REG_UNUSED_TIMEOUT = 2'd3;

  localparam code_t ACTIVE_TIMEOUT_RESET = 16'd500;
  localparam code_t UNUSED_TIMEOUT_RESET = 16'd300;

endpackage

/* rtl/core/oneshot_modifier_fsm_unit.sv */
// One-shot modifier key controller. Each request is either a key event or a one-millisecond
// tick, and each request produces exactly one result carrying the action (engage or release
// the target code), the target code when an action is given, and the new phase. The phase
// and the saturating tick counter are updated at the accepting edge and the result appears in
// an output register on the next cycle, so one request per cycle is sustained; a stalled
// result holds the request side only until it is taken. The trigger code, target code and both
// timeouts are written through the APB port at byte addresses 0, 4, 8 and 12; the user must
// write them only while the block is idle, which the block itself does not enforce.
module oneshot_modifier_fsm_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  op,
  input  osm_pkg::code_t        keycode,
  input  logic                  pressed,
  input  logic                  is_cancel,
  input  logic                  is_ignored,
  output logic                  res_valid,
  input  logic                  res_ready,
  output osm_pkg::action_t      action,
  output osm_pkg::code_t        target_out,
  output osm_pkg::phase_t       phase_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam osm_pkg::phase_t PH_IDLE        = 3'd0;
  localparam osm_pkg::phase_t PH_DOWN_UNUSED = 3'd1;
  localparam osm_pkg::phase_t PH_DOWN_USED   = 3'd2;
  localparam osm_pkg::phase_t PH_QUEUED      = 3'd3;
  localparam osm_pkg::phase_t PH_QUEUED_USED = 3'd4;

  osm_pkg::code_t   trigger_code;
  osm_pkg::code_t   target_code;
  osm_pkg::code_t   active_timeout;
  osm_pkg::code_t   unused_timeout;

  osm_pkg::phase_t  phase;
  osm_pkg::phase_t  phase_next;
  osm_pkg::code_t   elapsed;
  osm_pkg::code_t   elapsed_next;
  osm_pkg::code_t   elapsed_inc;
  osm_pkg::action_t act;

  osm_pkg::reg_idx_t reg_idx;
  logic              cfg_write;
  logic              req_take;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign req_ready = !res_valid || res_ready;
  assign req_take  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_code   <= '0;
      target_code    <= '0;
      active_timeout <= osm_pkg::ACTIVE_TIMEOUT_RESET;
      unused_timeout <= osm_pkg::UNUSED_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        osm_pkg::REG_TRIGGER_CODE:   trigger_code   <= pwdata[15:0];
        osm_pkg::REG_TARGET_CODE:    target_code    <= pwdata[15:0];
        osm_pkg::REG_ACTIVE_TIMEOUT: active_timeout <= pwdata[15:0];
        osm_pkg::REG_UNUSED_TIMEOUT: unused_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      osm_pkg::REG_TRIGGER_CODE:   prdata = {16'd0, trigger_code};
      osm_pkg::REG_TARGET_CODE:    prdata = {16'd0, target_code};
      osm_pkg::REG_ACTIVE_TIMEOUT: prdata = {16'd0, active_timeout};
      osm_pkg::REG_UNUSED_TIMEOUT: prdata = {16'd0, unused_timeout};
      default:                     prdata = '0;
    endcase
  end

  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 16'd1;

  always_comb begin
    phase_next   = phase;
    elapsed_next = elapsed;
    act          = osm_pkg::ACT_NONE;
    if (op) begin
      elapsed_next = elapsed_inc;
      if (phase == PH_QUEUED) begin
        if (elapsed_inc >= active_timeout) begin
          phase_next   = PH_IDLE;
          elapsed_next = '0;
          act          = osm_pkg::ACT_RELEASE;
        end
      end else if (phase == PH_DOWN_UNUSED) begin
        if (elapsed_inc >= unused_timeout) begin
          phase_next   = PH_DOWN_USED;
          elapsed_next = '0;
        end
      end
    end else if (keycode == trigger_code) begin
      if (pressed) begin
        if (phase == PH_IDLE) begin
          act = osm_pkg::ACT_ENGAGE;
        end
        phase_next   = PH_DOWN_UNUSED;
        elapsed_next = '0;
      end else if (phase == PH_DOWN_UNUSED) begin
        phase_next   = PH_QUEUED;
        elapsed_next = '0;
      end else if (phase == PH_DOWN_USED) begin
        phase_next = PH_IDLE;
        act        = osm_pkg::ACT_RELEASE;
      end
    end else if (pressed) begin
      // A cancel key ends a queued one-shot; the idle phase it leaves is then untouched.
      if (is_cancel && (phase == PH_QUEUED || phase == PH_QUEUED_USED)) begin
        phase_next = PH_IDLE;
        act        = osm_pkg::ACT_RELEASE;
      end else if (!is_ignored) begin
        case (phase)
          PH_DOWN_UNUSED: phase_next = PH_DOWN_USED;
          PH_QUEUED:      phase_next = PH_QUEUED_USED;
          PH_QUEUED_USED: begin
            phase_next = PH_IDLE;
            act        = osm_pkg::ACT_RELEASE;
          end
          default: ;
        endcase
      end
    end else if (!is_ignored && phase == PH_QUEUED_USED) begin
      phase_next = PH_IDLE;
      act        = osm_pkg::ACT_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      elapsed   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (req_take) begin
        phase     <= phase_next;
        elapsed   <= elapsed_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      action     <= act;
      target_out <= (act != osm_pkg::ACT_NONE) ? target_code : '0;
      phase_out  <= phase_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res_valid && action == osm_pkg::ACT_RELEASE |-> phase_out == PH_IDLE)
    else $error("release result without idle phase");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && action == osm_pkg::ACT_ENGAGE |-> phase_out == PH_DOWN_UNUSED)
    else $error("engage result without down unused phase");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && action == osm_pkg::ACT_NONE |-> target_out == '0)
    else $error("target code shown without an action");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(phase_out) && $stable(action))
    else $error("stalled result lost or changed");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase_out == phase)
    else $error("shown phase differs from state");

endmodule

/* tb/sv/oneshot_modifier_fsm_unit_tb.sv */
module oneshot_modifier_fsm_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam osm_pkg::phase_t PH_IDLE        = 3'd0;
  localparam osm_pkg::phase_t PH_DOWN_UNUSED = 3'd1;
  localparam osm_pkg::phase_t PH_DOWN_USED   = 3'd2;
  localparam osm_pkg::phase_t PH_QUEUED      = 3'd3;
  localparam osm_pkg::phase_t PH_QUEUED_USED = 3'd4;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 4;

  typedef struct packed {
    osm_pkg::action_t act;
    osm_pkg::code_t   target;
    osm_pkg::phase_t  phase;
  } key_action_t;

  class oneshot_scoreboard;
    osm_pkg::code_t trig_key;
    osm_pkg::code_t target_key;
    osm_pkg::code_t active_limit;
    osm_pkg::code_t unused_limit;
    osm_pkg::phase_t phase;
    osm_pkg::code_t ticks;
    key_action_t expected_actions[$];
    int mismatches;
    int results_seen;

    function new();
      trig_key = '0;
      target_key = '0;
      active_limit = osm_pkg::ACTIVE_TIMEOUT_RESET;
      unused_limit = osm_pkg::UNUSED_TIMEOUT_RESET;
      phase = PH_IDLE;
      ticks = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_register(osm_pkg::reg_idx_t idx, osm_pkg::code_t value);
      case (idx)
        osm_pkg::REG_TRIGGER_CODE:   trig_key = value;
        osm_pkg::REG_TARGET_CODE:    target_key = value;
        osm_pkg::REG_ACTIVE_TIMEOUT: active_limit = value;
        osm_pkg::REG_UNUSED_TIMEOUT: unused_limit = value;
        default: ;
      endcase
    endfunction

    function key_action_t predict_key_action(bit tick, osm_pkg::code_t key, bit down,
                                             bit cancel, bit ignored);
      key_action_t res;
      osm_pkg::action_t act;
      act = osm_pkg::ACT_NONE;
      if (tick) begin
        if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
        if (phase == PH_QUEUED) begin
          if (ticks >= active_limit) begin
            phase = PH_IDLE;
            ticks = '0;
            act = osm_pkg::ACT_RELEASE;
          end
        end else if (phase == PH_DOWN_UNUSED) begin
          if (ticks >= unused_limit) begin
            phase = PH_DOWN_USED;
            ticks = '0;
          end
        end
      end else if (key == trig_key) begin
        if (down) begin
          if (phase == PH_IDLE) act = osm_pkg::ACT_ENGAGE;
          phase = PH_DOWN_UNUSED;
          ticks = '0;
        end else if (phase == PH_DOWN_UNUSED) begin
          phase = PH_QUEUED;
          ticks = '0;
        end else if (phase == PH_DOWN_USED) begin
          phase = PH_IDLE;
          act = osm_pkg::ACT_RELEASE;
        end
      end else if (down) begin
        if (cancel && (phase == PH_QUEUED || phase == PH_QUEUED_USED)) begin
          phase = PH_IDLE;
          act = osm_pkg::ACT_RELEASE;
        end
        if (!ignored) begin
          if (phase == PH_DOWN_UNUSED) begin
            phase = PH_DOWN_USED;
          end else if (phase == PH_QUEUED) begin
            phase = PH_QUEUED_USED;
          end else if (phase == PH_QUEUED_USED) begin
            phase = PH_IDLE;
            act = osm_pkg::ACT_RELEASE;
          end
        end
      end else if (!ignored && phase == PH_QUEUED_USED) begin
        phase = PH_IDLE;
        act = osm_pkg::ACT_RELEASE;
      end
      res.act = act;
      res.target = (act != osm_pkg::ACT_NONE) ? target_key : '0;
      res.phase = phase;
      return res;
    endfunction

    function void note_request(bit tick, osm_pkg::code_t key, bit down, bit cancel,
                               bit ignored);
      expected_actions.push_back(predict_key_action(tick, key, down, cancel, ignored));
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task check_result(osm_pkg::action_t act, osm_pkg::code_t target, osm_pkg::phase_t ph);
      key_action_t exp;
      results_seen++;
      if (expected_actions.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
        exp = expected_actions.pop_front();
        if (act !== exp.act)
          report_mismatch($sformatf("result %0d action: expected %0d, got %0d",
                                    results_seen, exp.act, act));
        if (target !== exp.target)
          report_mismatch($sformatf("result %0d target_out: expected %h, got %h",
                                    results_seen, exp.target, target));
        if (ph !== exp.phase)
          report_mismatch($sformatf("result %0d phase_out: expected %0d, got %0d",
                                    results_seen, exp.phase, ph));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic op = 1'b0;
  osm_pkg::code_t keycode = '0;
  logic pressed = 1'b0;
  logic is_cancel = 1'b0;
  logic is_ignored = 1'b0;
  logic res_valid;
  logic res_ready = 1'b0;
  osm_pkg::action_t action;
  osm_pkg::code_t target_out;
  osm_pkg::phase_t phase_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  oneshot_scoreboard sb = new();
  bit sender_calm = 1'b0;
  int cycles = 0;

  oneshot_modifier_fsm_unit uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .op         (op),
    .keycode    (keycode),
    .pressed    (pressed),
    .is_cancel  (is_cancel),
    .is_ignored (is_ignored),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .action     (action),
    .target_out (target_out),
    .phase_out  (phase_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the request side backs up.
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) sb.check_result(action, target_out, phase_out);
      if (!held && sb.results_seen >= 400) begin
        held = 1'b1;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (sb.results_seen >= 600 && sb.results_seen < 800) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic apb_access(bit wr, osm_pkg::reg_idx_t idx, osm_pkg::code_t value,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_register(osm_pkg::reg_idx_t idx, osm_pkg::code_t value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    sb.write_register(idx, value);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== {16'h0000, value})
      sb.report_mismatch($sformatf("register %0d read back %h, expected %h", idx, rd, value));
  endtask

  task automatic send_request(bit tick, osm_pkg::code_t key, bit down, bit cancel,
                              bit ignored);
    while (!sender_calm && $urandom_range(99) < 12) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    op <= tick;
    keycode <= key;
    pressed <= down;
    is_cancel <= cancel;
    is_ignored <= ignored;
    do @(posedge clk); while (!req_ready);
    sb.note_request(tick, key, down, cancel, ignored);
  endtask

  task automatic send_random();
    int pick;
    osm_pkg::code_t key;
    pick = $urandom_range(99);
    key = osm_pkg::code_t'($urandom);
    if (pick < 35)
      send_request(1'b1, key, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    else if (pick < 60)
      send_request(1'b0, sb.trig_key, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    else
      send_request(1'b0, key, 1'($urandom_range(1)), $urandom_range(99) < 25,
                   $urandom_range(99) < 30);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sb.expected_actions.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic configure(osm_pkg::code_t trig, osm_pkg::code_t target,
                           osm_pkg::code_t act_to, osm_pkg::code_t unused_to);
    settle();
    set_register(osm_pkg::REG_TRIGGER_CODE, trig);
    set_register(osm_pkg::REG_TARGET_CODE, target);
    set_register(osm_pkg::REG_ACTIVE_TIMEOUT, act_to);
    set_register(osm_pkg::REG_UNUSED_TIMEOUT, unused_to);
  endtask

  task automatic run_random(int count, bit calm);
    sender_calm = calm;
    repeat (count) send_random();
  endtask

  initial begin
    osm_pkg::code_t t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    t = 16'h8001;
    configure(t, 16'hFFFF, 16'd3, 16'd2);
    send_request(1'b0, 16'h0010, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, 16'h0010, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b1, 1'b0, 1'b0);
    send_request(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_request(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b1, 1'b1, 1'b1);
    send_request(1'b0, 16'h0020, 1'b1, 1'b0, 1'b1);
    send_request(1'b0, 16'h0020, 1'b1, 1'b1, 1'b0);
    send_request(1'b0, t, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b1, 1'b0);
    send_request(1'b0, 16'h0030, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, 16'h0030, 1'b1, 1'b0, 1'b1);
    send_request(1'b0, 16'h0030, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, 16'h0030, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, 16'h0040, 1'b1, 1'b1, 1'b1);
    send_request(1'b0, t, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, 16'h0040, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, 16'h0040, 1'b1, 1'b1, 1'b0);
    send_request(1'b0, t, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b1, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    repeat (3) send_request(1'b1, 16'h7FFF, 1'b0, 1'b0, 1'b0);

    configure(osm_pkg::code_t'($urandom), osm_pkg::code_t'($urandom),
              osm_pkg::code_t'($urandom_range(1, 6)), osm_pkg::code_t'($urandom_range(1, 6)));
    run_random(220, 1'b0);
    configure(16'h0000, 16'h0000, 16'd0, 16'd0);
    run_random(220, 1'b0);
    configure(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
    run_random(220, 1'b1);
    configure(osm_pkg::code_t'($urandom), osm_pkg::code_t'($urandom),
              osm_pkg::code_t'($urandom_range(1, 12)), osm_pkg::code_t'($urandom_range(1, 12)));
    run_random(220, 1'b0);
    configure(osm_pkg::code_t'($urandom), osm_pkg::code_t'($urandom),
              osm_pkg::code_t'($urandom_range(1, 30)), osm_pkg::code_t'($urandom_range(1, 30)));
    run_random(220, 1'b0);

    // Largest timeouts: neither the held trigger nor the queued one-shot times out on a
    // short run of ticks.
    t = 16'h1234;
    configure(t, osm_pkg::code_t'($urandom), 16'hFFFF, 16'hFFFF);
    sender_calm = 1'b1;
    send_request(1'b0, t, 1'b1, 1'b0, 1'b0);
    repeat (20) send_request(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, t, 1'b0, 1'b0, 1'b0);
    repeat (20) send_request(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0);

    settle();
    if (sb.mismatches == 0 && sb.expected_actions.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
